FILE: rtl/core/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types and constants of the pairwise cosine similarity unit.
// ----------------------------------------------------------------------------
package pcs_pkg;

    localparam int IDX_W      = 12;
    localparam int COORD_W    = 16;
    localparam int LEN_W      = 17;
    localparam int SIM_W      = 17;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int DEN_W      = 2 * LEN_W;
    localparam int ACC_W      = DEN_W + 1;
    localparam int STEPS      = LEN_W;
    localparam int DEF_POINTS = 4096;

    localparam logic [SIM_W-1:0] SIM_ONE = SIM_W'(65536);

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [LEN_W-1:0]   len;
    } t_point;

    // per-stage control and the load payload that rides to the write port
    typedef struct packed {
        logic               valid;
        t_op                op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_meta;

    // working values of the shared root / divide step
    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic [LEN_W-1:0] res;
        logic [DEN_W-1:0] den;
        logic             zero;
        logic             sat;
    } t_work;

endpackage

FILE: rtl/core/pcs_point_mem.sv
// ----------------------------------------------------------------------------
// pcs_point_mem
// Point store: coordinates and length, two registered read ports, one write.
// ----------------------------------------------------------------------------
module pcs_point_mem
    import pcs_pkg::*;
#(
    parameter int DEPTH  = DEF_POINTS,
    parameter int ADDR_W = $clog2(DEF_POINTS)
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_addr_a,
    input  logic [ADDR_W-1:0] i_addr_b,
    output t_point            o_pt_a,
    output t_point            o_pt_b,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_point            i_wr_pt
);

    t_point r_mem [DEPTH];
    t_point r_pt_a;
    t_point r_pt_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_pt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_pt_a <= r_mem[i_addr_a];
            r_pt_b <= r_mem[i_addr_b];
        end
    end

    assign o_pt_a = r_pt_a;
    assign o_pt_b = r_pt_b;

endmodule

FILE: rtl/core/pcs_arith.sv
// ----------------------------------------------------------------------------
// pcs_arith
// Product and sum stages: squares for a load, dot product and length
// product for a query, then the start values of the step chain.
// ----------------------------------------------------------------------------
module pcs_arith
    import pcs_pkg::*;
#(
    parameter int ADDR_W = $clog2(DEF_POINTS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  t_meta             i_meta,
    input  logic [ADDR_W-1:0] i_slot,
    input  t_point            i_pt_a,
    input  t_point            i_pt_b,
    output t_meta             o_meta_mid,
    output logic [ADDR_W-1:0] o_slot_mid,
    output t_meta             o_meta,
    output logic [ADDR_W-1:0] o_slot,
    output t_work             o_work
);

    t_meta              r_meta_p2, r_meta_p3;
    logic [ADDR_W-1:0]  r_slot_p2, r_slot_p3;
    logic [PROD_W-1:0]  r_prod0, r_prod1;
    logic [DEN_W-1:0]   r_den;
    logic               r_zero;
    t_work              r_work;

    logic [COORD_W-1:0] w_m0a, w_m0b, w_m1a, w_m1b;
    logic [SUM_W-1:0]   w_sum;
    t_work              n_work;

    always_comb begin
        if (i_meta.op == OP_QUERY) begin
            w_m0a = i_pt_a.x;
            w_m0b = i_pt_b.x;
            w_m1a = i_pt_a.y;
            w_m1b = i_pt_b.y;
        end else begin
            w_m0a = i_meta.x;
            w_m0b = i_meta.x;
            w_m1a = i_meta.y;
            w_m1b = i_meta.y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta_p2.valid <= 1'b0;
            r_meta_p3.valid <= 1'b0;
        end else if (i_adv) begin
            r_meta_p2 <= i_meta;
            r_meta_p3 <= r_meta_p2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_slot_p2 <= i_slot;
            r_slot_p3 <= r_slot_p2;
            r_prod0   <= w_m0a * w_m0b;
            r_prod1   <= w_m1a * w_m1b;
            r_den     <= i_pt_a.len * i_pt_b.len;
            r_zero    <= (i_meta.op == OP_QUERY) &&
                         ((i_pt_a.len == '0) || (i_pt_b.len == '0));
            r_work    <= n_work;
        end
    end

    always_comb begin
        w_sum      = SUM_W'(r_prod0) + SUM_W'(r_prod1);
        n_work.res = '0;
        n_work.zero = r_zero;
        if (r_zero) begin
            n_work.acc = '0;
            n_work.den = DEN_W'(1);
        end else begin
            n_work.acc = ACC_W'(w_sum);
            n_work.den = r_den;
        end
        // quotient would need more than 17 bits
        n_work.sat = (r_meta_p2.op == OP_QUERY) && !r_zero &&
                     ({2'b00, w_sum} >= {r_den, 1'b0});
    end

    assign o_meta_mid = r_meta_p2;
    assign o_slot_mid = r_slot_p2;
    assign o_meta     = r_meta_p3;
    assign o_slot     = r_slot_p3;
    assign o_work     = r_work;

endmodule

FILE: rtl/core/pcs_step.sv
// ----------------------------------------------------------------------------
// pcs_step
// One stage of the shared step chain: a square-root bit for a load or a
// quotient bit of the restoring division for a query.
// ----------------------------------------------------------------------------
module pcs_step
    import pcs_pkg::*;
#(
    parameter int J      = 0,
    parameter int ADDR_W = $clog2(DEF_POINTS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  t_meta             i_meta,
    input  logic [ADDR_W-1:0] i_slot,
    input  t_work             i_work,
    output t_meta             o_meta,
    output logic [ADDR_W-1:0] o_slot,
    output t_work             o_work
);

    localparam int K = STEPS - 1 - J;

    t_meta             r_meta;
    logic [ADDR_W-1:0] r_slot;
    t_work             r_work;

    t_work            n_work;
    logic [ACC_W-1:0] w_diff;
    logic [ACC_W-1:0] w_trial;
    logic [ACC_W-1:0] w_den;

    always_comb begin
        n_work  = i_work;
        w_diff  = (ACC_W'(i_work.res) << (K + 1)) + (ACC_W'(1) << (2 * K));
        w_trial = (J == 0) ? i_work.acc : (i_work.acc << 1);
        w_den   = ACC_W'(i_work.den);
        if (i_meta.op == OP_LOAD) begin
            if (i_work.acc >= w_diff) begin
                n_work.acc = i_work.acc - w_diff;
                n_work.res = i_work.res | (LEN_W'(1) << K);
            end
        end else begin
            if (w_trial >= w_den) begin
                n_work.acc = w_trial - w_den;
                n_work.res = {i_work.res[LEN_W-2:0], 1'b1};
            end else begin
                n_work.acc = w_trial;
                n_work.res = {i_work.res[LEN_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta.valid <= 1'b0;
        end else if (i_adv) begin
            r_meta <= i_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_slot <= i_slot;
            r_work <= n_work;
        end
    end

    assign o_meta = r_meta;
    assign o_slot = r_slot;
    assign o_work = r_work;

endmodule

FILE: rtl/core/pairwise_cosine_similarity_unit.sv
// ----------------------------------------------------------------------------
// pairwise_cosine_similarity_unit
// Point store with cosine similarity queries between stored points.
// ----------------------------------------------------------------------------
// Input stream s_axis: tuser is the op (load or query), tdata carries the
// two indices and the coordinates of a loaded point. A load writes x, y and
// the computed length sqrt(x*x+y*y) to the slot and returns nothing. A query
// returns one transfer on m_axis: tdata holds the Q1.16 similarity, tuser
// flags a zero-length point (similarity then 0).
// Throughput is one item per cycle unless the receiver stalls or a hazard
// holds tready low: a pipeline of one read stage, two product/sum stages,
// a chain of 17 shared root/divide step stages and an output register.
// A query that reads a slot still being written by a load in flight holds
// tready low until that load's write has been done.
// Reset clears all stage valid bits; the store itself is not cleared.
// When the receiver stalls a pending result, the whole pipeline holds and
// s_axis_tready drops; nothing is lost.
// ----------------------------------------------------------------------------
module pairwise_cosine_similarity_unit
    import pcs_pkg::*;
#(
    parameter int POINTS = DEF_POINTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // index_a[11:0], index_b[23:12], coord_x[39:24], coord_y[55:40]
    input  logic [55:0] s_axis_tdata,
    // op[0]
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // similarity[16:0], zero padding above
    output logic [23:0] m_axis_tdata,
    // zero_length[0]
    output logic [0:0]  m_axis_tuser
);

    localparam int ADDR_W = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int NHAZ   = STEPS + 4;

    logic                w_adv;
    logic                w_hazard;
    logic                w_accept;
    logic [IDX_W-1:0]    w_idx  [2];
    logic [ADDR_W-1:0]   w_slot [2];

    t_meta               r_meta_p1;
    logic [ADDR_W-1:0]   r_slot_p1;
    t_point              w_pt_a, w_pt_b;

    t_meta               w_meta_p2, w_meta_p3;
    logic [ADDR_W-1:0]   w_slot_p2, w_slot_p3;
    t_work               w_work_p3;

    t_meta               w_st_meta [STEPS+1];
    logic [ADDR_W-1:0]   w_st_slot [STEPS+1];
    t_work               w_st_work [STEPS+1];

    t_meta               r_fin_meta;
    logic [ADDR_W-1:0]   r_fin_slot;
    logic [LEN_W-1:0]    r_fin_res;
    logic                r_fin_zero;
    logic [LEN_W-1:0]    n_fin_res;

    t_meta               w_haz_meta [NHAZ];
    logic [ADDR_W-1:0]   w_haz_slot [NHAZ];
    t_point              w_wr_pt;
    t_work               w_last;

    assign w_idx[0] = s_axis_tdata[11:0];
    assign w_idx[1] = s_axis_tdata[23:12];

    // index to slot, modulo the store depth
    for (genvar g = 0; g < 2; g++) begin : g_slot
        if (POINTS >= (1 << IDX_W)) begin : g_wide
            assign w_slot[g] = ADDR_W'(w_idx[g]);
        end else begin : g_mod
            localparam longint RECIP = (64'd1 << 24) / POINTS;
            logic [IDX_W+23:0]  w_prod;
            logic [IDX_W-1:0]   w_q;
            logic [IDX_W+23:0]  w_qp;
            logic [IDX_W-1:0]   w_rem;
            always_comb begin
                w_prod = (IDX_W + 24)'(w_idx[g]) * (IDX_W + 24)'(RECIP);
                w_q    = w_prod[IDX_W+23:24];
                w_qp   = (IDX_W + 24)'(w_q) * (IDX_W + 24)'(POINTS);
                w_rem  = w_idx[g] - w_qp[IDX_W-1:0];
                if (w_rem >= IDX_W'(POINTS)) begin
                    w_rem = w_rem - IDX_W'(POINTS);
                end
                w_slot[g] = w_rem[ADDR_W-1:0];
            end
        end
    end

    assign m_axis_tvalid = r_fin_meta.valid && (r_fin_meta.op == OP_QUERY);
    assign w_adv         = !m_axis_tvalid || m_axis_tready;

    // slots still waiting for their load's write
    assign w_haz_meta[0] = r_meta_p1;
    assign w_haz_slot[0] = r_slot_p1;
    assign w_haz_meta[1] = w_meta_p2;
    assign w_haz_slot[1] = w_slot_p2;
    assign w_haz_meta[2] = w_meta_p3;
    assign w_haz_slot[2] = w_slot_p3;
    for (genvar g = 1; g <= STEPS; g++) begin : g_haz
        assign w_haz_meta[g+2] = w_st_meta[g];
        assign w_haz_slot[g+2] = w_st_slot[g];
    end
    assign w_haz_meta[NHAZ-1] = r_fin_meta;
    assign w_haz_slot[NHAZ-1] = r_fin_slot;

    always_comb begin
        w_hazard = 1'b0;
        for (int i = 0; i < NHAZ; i++) begin
            if (w_haz_meta[i].valid && (w_haz_meta[i].op == OP_LOAD) &&
                ((w_haz_slot[i] == w_slot[0]) || (w_haz_slot[i] == w_slot[1]))) begin
                w_hazard = 1'b1;
            end
        end
        if (s_axis_tuser[0] == OP_LOAD) begin
            w_hazard = 1'b0;
        end
    end

    assign s_axis_tready = w_adv && !w_hazard;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta_p1.valid <= 1'b0;
        end else if (w_adv) begin
            r_meta_p1.valid <= w_accept;
            r_meta_p1.op    <= t_op'(s_axis_tuser[0]);
            r_meta_p1.x     <= s_axis_tdata[39:24];
            r_meta_p1.y     <= s_axis_tdata[55:40];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_slot_p1 <= w_slot[0];
        end
    end

    assign w_wr_pt.x   = r_fin_meta.x;
    assign w_wr_pt.y   = r_fin_meta.y;
    assign w_wr_pt.len = r_fin_res;

    pcs_point_mem #(
        .DEPTH  (POINTS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_adv),
        .i_addr_a  (w_slot[0]),
        .i_addr_b  (w_slot[1]),
        .o_pt_a    (w_pt_a),
        .o_pt_b    (w_pt_b),
        .i_wr_en   (r_fin_meta.valid && (r_fin_meta.op == OP_LOAD)),
        .i_wr_addr (r_fin_slot),
        .i_wr_pt   (w_wr_pt)
    );

    pcs_arith #(
        .ADDR_W (ADDR_W)
    ) u_arith (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_meta     (r_meta_p1),
        .i_slot     (r_slot_p1),
        .i_pt_a     (w_pt_a),
        .i_pt_b     (w_pt_b),
        .o_meta_mid (w_meta_p2),
        .o_slot_mid (w_slot_p2),
        .o_meta     (w_meta_p3),
        .o_slot     (w_slot_p3),
        .o_work     (w_work_p3)
    );

    assign w_st_meta[0] = w_meta_p3;
    assign w_st_slot[0] = w_slot_p3;
    assign w_st_work[0] = w_work_p3;

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        pcs_step #(
            .J      (g),
            .ADDR_W (ADDR_W)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_meta  (w_st_meta[g]),
            .i_slot  (w_st_slot[g]),
            .i_work  (w_st_work[g]),
            .o_meta  (w_st_meta[g+1]),
            .o_slot  (w_st_slot[g+1]),
            .o_work  (w_st_work[g+1])
        );
    end

    assign w_last = w_st_work[STEPS];

    always_comb begin
        if (w_st_meta[STEPS].op == OP_LOAD) begin
            n_fin_res = w_last.res;
        end else if (w_last.zero) begin
            n_fin_res = '0;
        end else if (w_last.sat || (w_last.res > SIM_ONE)) begin
            n_fin_res = SIM_ONE;
        end else begin
            n_fin_res = w_last.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_meta.valid <= 1'b0;
        end else if (w_adv) begin
            r_fin_meta <= w_st_meta[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fin_slot <= w_st_slot[STEPS];
            r_fin_res  <= n_fin_res;
            r_fin_zero <= w_last.zero;
        end
    end

    assign m_axis_tdata = {7'b0, r_fin_res};
    assign m_axis_tuser = r_fin_zero;

endmodule

FILE: verif/pcs_checker.sv
// ----------------------------------------------------------------------------
// pcs_checker
// Watches both streams of the cosine similarity unit, keeps its own point
// store, predicts each query result and compares it with the output stream.
// ----------------------------------------------------------------------------
module pcs_checker
    import pcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,
    input  logic [0:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic [0:0]  m_axis_tuser,
    output int          o_errors,
    output int          o_pending,
    output int          o_queries,
    output int          o_zero_hits,
    output int          o_saturated
);

    typedef struct packed {
        logic [SIM_W-1:0] sim;
        logic             zero;
    } t_answer;

    logic [COORD_W-1:0] pt_x [DEF_POINTS];
    logic [COORD_W-1:0] pt_y [DEF_POINTS];
    logic [LEN_W-1:0]   pt_len [DEF_POINTS];
    t_answer            answers_due [$];

    // floor square root by bitwise trial
    function automatic logic [LEN_W-1:0] isqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = 0;
        for (int b = LEN_W - 1; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return r[LEN_W-1:0];
    endfunction

    function automatic t_answer cosine(input int a, input int b);
        t_answer     ans;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        ans = '0;
        if (pt_len[a] == 0 || pt_len[b] == 0) begin
            ans.zero = 1'b1;
        end else begin
            num = 64'(pt_x[a]) * 64'(pt_x[b]) + 64'(pt_y[a]) * 64'(pt_y[b]);
            den = 64'(pt_len[a]) * 64'(pt_len[b]);
            q = (num << 16) / den;
            ans.sim = (q > 64'd65536) ? SIM_ONE : q[SIM_W-1:0];
        end
        return ans;
    endfunction

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_queries = 0;
        o_zero_hits = 0;
        o_saturated = 0;
    end

    always @(posedge i_clk) begin
        t_answer     exp_ans;
        logic [63:0] x;
        logic [63:0] y;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            if (t_op'(s_axis_tuser[0]) == OP_LOAD) begin
                x = 64'(s_axis_tdata[39:24]);
                y = 64'(s_axis_tdata[55:40]);
                pt_x[s_axis_tdata[11:0]]   <= x[15:0];
                pt_y[s_axis_tdata[11:0]]   <= y[15:0];
                pt_len[s_axis_tdata[11:0]] <= isqrt(x * x + y * y);
            end else begin
                exp_ans = cosine(int'(s_axis_tdata[11:0]), int'(s_axis_tdata[23:12]));
                answers_due.push_back(exp_ans);
                o_queries <= o_queries + 1;
                if (exp_ans.zero) o_zero_hits <= o_zero_hits + 1;
                if (exp_ans.sim == SIM_ONE) o_saturated <= o_saturated + 1;
            end
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected result sim=%0d zero=%0b", $time,
                         m_axis_tdata[16:0], m_axis_tuser[0]);
                o_errors <= o_errors + 1;
            end else begin
                exp_ans = answers_due.pop_front();
                if (m_axis_tdata[16:0] !== exp_ans.sim || m_axis_tuser[0] !== exp_ans.zero
                        || m_axis_tdata[23:17] !== 7'd0) begin
                    $display({"%0t: result mismatch expected sim=%0d zero=%0b",
                              " actual sim=%0d zero=%0b"},
                             $time, exp_ans.sim, exp_ans.zero, m_axis_tdata[16:0],
                             m_axis_tuser[0]);
                    o_errors <= o_errors + 1;
                end
            end
        end
        o_pending <= answers_due.size();
    end

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the pairwise cosine similarity unit: directed
// loads and queries at the coordinate extremes, then random mixed traffic
// over several idle and stall phases, with a checker scoring every result.
// ----------------------------------------------------------------------------
module tb;
    import pcs_pkg::*;

    localparam int WATCHDOG = 20000;
    localparam int LATENCY  = 21;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    int errors;
    int pending;
    int queries;
    int zero_hits;
    int saturated;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int quiet_cycles;
    bit loaded [DEF_POINTS];
    int loaded_list [$];
    int loads_sent;

    pairwise_cosine_similarity_unit u_top (.*);

    pcs_checker u_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .o_errors(errors), .o_pending(pending), .o_queries(queries),
        .o_zero_hits(zero_hits), .o_saturated(saturated)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // receiver: random stalls, or a long forced hold-off
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            m_axis_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_item(input t_op op, input int a, input int b,
                             input logic [15:0] x, input logic [15:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {y, x, 12'(b), 12'(a)};
        do @(posedge i_clk); while (!s_axis_tready);
        if (op == OP_LOAD) begin
            loads_sent++;
            if (!loaded[a]) begin
                loaded[a] = 1'b1;
                loaded_list.push_back(a);
            end
        end
    endtask

    task automatic load_pt(input int a, input logic [15:0] x, input logic [15:0] y);
        send_item(OP_LOAD, a, $urandom_range(4095), x, y);
    endtask

    task automatic query_pt(input int a, input int b);
        send_item(OP_QUERY, a, b, 16'($urandom), 16'($urandom));
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'hffff;
            2: return 16'($urandom_range(15));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic random_phase(input int n, input int idle, input int stall);
        int a;
        int b;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int k = 0; k < n; k++) begin
            // small hot set keeps read-after-write hazards frequent
            if (loaded_list.size() < 2 || $urandom_range(99) < 35) begin
                a = ($urandom_range(1)) ? $urandom_range(15) : $urandom_range(4095);
                load_pt(a, rand_coord(), rand_coord());
            end else begin
                a = loaded_list[$urandom_range(loaded_list.size() - 1)];
                b = loaded_list[$urandom_range(loaded_list.size() - 1)];
                query_pt(a, b);
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_LOAD;
        m_axis_tready = 1'b0;
        hold_cycles = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        loads_sent = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, zero length, saturation, back-to-back hazards
        load_pt(0, 16'h0000, 16'h0000);
        load_pt(4095, 16'hffff, 16'hffff);
        load_pt(1, 16'hffff, 16'h0000);
        load_pt(2, 16'h0000, 16'hffff);
        load_pt(3, 16'h0001, 16'h0001);
        load_pt(4, 16'h0001, 16'h0000);
        query_pt(0, 4095);
        query_pt(4095, 0);
        query_pt(0, 0);
        query_pt(4095, 4095);
        query_pt(1, 2);
        query_pt(1, 4095);
        query_pt(3, 3);
        query_pt(3, 4);
        query_pt(4, 4);
        load_pt(5, 16'h1234, 16'habcd);
        query_pt(5, 5);
        load_pt(5, 16'h0000, 16'h0000);
        query_pt(5, 1);
        load_pt(2048, 16'h8000, 16'h7fff);
        query_pt(2048, 3);
        query_pt(2048, 4095);
        drain();

        random_phase(300, 0, 0);
        random_phase(250, 58, 0);
        random_phase(250, 0, 58);

        // long receiver hold-off while the sender keeps offering
        hold_cycles <= 200;
        random_phase(60, 0, 0);
        drain();

        random_phase(250, 31, 31);
        random_phase(150, 0, 0);
        drain();

        $display("covered %0d loads and %0d queries (%0d zero length, %0d saturated)",
                 loads_sent, queries, zero_hits, saturated);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/pcs_pkg.sv
rtl/core/pcs_point_mem.sv
rtl/core/pcs_arith.sv
rtl/core/pcs_step.sv
rtl/core/pairwise_cosine_similarity_unit.sv
verif/pcs_checker.sv
verif/tb.sv
